### hw/rtl/sorted_unique_key_table_defines.svh
// Assertion macros for the sorted unique-key table.
`ifndef SORTED_UNIQUE_KEY_TABLE_DEFINES_SVH
`define SORTED_UNIQUE_KEY_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SUKT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_unique_key_table: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SUKT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_unique_key_table: next-cycle check failed");

`endif

### hw/rtl/sukt_pkg.sv
// Shared types and constants of the sorted unique-key table.
`timescale 1ns / 1ps

package sukt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int KEY_W       = 32;
    localparam int ATTR_W      = 16;
    localparam int OUT_W       = 6;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_LOOKUP = 1'b1
    } command_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              kind;
        logic [ATTR_W-1:0] attr;
    } entry_t;

    // Count or index value masked or extended to the 6-bit result fields.
    function automatic logic [OUT_W-1:0] out6(input logic [CNT_W-1:0] v);
        logic [CNT_W+OUT_W-1:0] w;
        w = {{OUT_W{1'b0}}, v};
        return w[OUT_W-1:0];
    endfunction

endpackage

### hw/rtl/sorted_unique_key_table.sv
// Lookup: the scan runs up from position 0 and stops at a hit, a larger key or the last entry.
// Insert: scan as above, then each entry from the end down to the insert position is shifted up
// by one, and the new entry is written last.
// One transaction at a time: busy stays high from accept until the done strobe.
// Results are one-cycle strobed and cannot be stalled by the receiver.
// Reset (rst_n low, async) empties the table; entry storage itself is not cleared.
`timescale 1ns / 1ps

`include "sorted_unique_key_table_defines.svh"

module sorted_unique_key_table
    import sukt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              command,
    input  logic [KEY_W-1:0]  part_key,
    input  logic              part_kind,
    input  logic [ATTR_W-1:0] part_attribute,
    output logic              done,
    output logic [2:0]        status,
    output logic [OUT_W-1:0]  position,
    output logic              found_kind,
    output logic [ATTR_W-1:0] found_attribute,
    output logic [OUT_W-1:0]  entry_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MISS,
        S_SHIFT,
        S_WRITE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   ins_reg, ins_next;
    logic               cmd_reg, cmd_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               kind_reg, kind_next;
    logic [ATTR_W-1:0]  attr_reg, attr_next;
    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic [OUT_W-1:0]   position_reg, position_next;
    logic               found_kind_reg, found_kind_next;
    logic [ATTR_W-1:0]  found_attr_reg, found_attr_next;

    // Table memory, one read and one write per cycle
    entry_t             mem [TABLE_DEPTH];
    entry_t             rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;

    // Shared compare unit and counters
    logic               key_hit;
    logic               key_above;
    logic               scan_last;
    logic               table_full;
    logic               ins_at_end;
    logic [CNT_W-1:0]   count_m1;

    assign key_hit    = (rd_data_reg.key == key_reg);
    assign key_above  = (rd_data_reg.key > key_reg);
    assign scan_last  = (({1'b0, idx_reg} + CNT_W'(1)) == count_reg);
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));
    assign ins_at_end = ({1'b0, ins_reg} == count_reg);
    assign count_m1   = count_reg - CNT_W'(1);

    // Sequencer next-state logic
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        ins_next        = ins_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        kind_next       = kind_reg;
        attr_next       = attr_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        position_next   = position_reg;
        found_kind_next = found_kind_reg;
        found_attr_next = found_attr_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                rd_addr = '0;
                if (start)
                begin
                    cmd_next  = command;
                    key_next  = part_key;
                    kind_next = part_kind;
                    attr_next = part_attribute;
                    idx_next  = '0;
                    ins_next  = '0;
                    if (count_reg == '0)
                        state_next = S_MISS;
                    else
                        state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                rd_addr = idx_reg + IDX_W'(1);
                if (key_hit)
                begin
                    done_next       = 1'b1;
                    status_next     = (cmd_reg == CMD_LOOKUP) ? ST_FOUND : ST_DUPLICATE;
                    position_next   = out6({1'b0, idx_reg});
                    found_kind_next = rd_data_reg.kind;
                    found_attr_next = rd_data_reg.attr;
                    state_next      = S_IDLE;
                end
                else if (key_above)
                begin
                    ins_next   = idx_reg;
                    state_next = S_MISS;
                end
                else if (scan_last)
                begin
                    // wraps only when the table is full, where it is unused
                    ins_next   = idx_reg + IDX_W'(1);
                    state_next = S_MISS;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_MISS:
            begin
                rd_addr = count_m1[IDX_W-1:0];
                if (cmd_reg == CMD_LOOKUP || table_full)
                begin
                    done_next       = 1'b1;
                    status_next     = (cmd_reg == CMD_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
                    position_next   = out6(count_reg);
                    found_kind_next = 1'b0;
                    found_attr_next = '0;
                    state_next      = S_IDLE;
                end
                else if (ins_at_end)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    idx_next   = count_m1[IDX_W-1:0];
                    state_next = S_SHIFT;
                end
            end

            // Move entry idx up by one, reading the next lower entry meanwhile
            S_SHIFT:
            begin
                rd_addr = idx_reg - IDX_W'(1);
                wr_en   = 1'b1;
                wr_addr = idx_reg + IDX_W'(1);
                wr_data = rd_data_reg;
                if (idx_reg == ins_reg)
                    state_next = S_WRITE;
                else
                    idx_next = idx_reg - IDX_W'(1);
            end

            S_WRITE:
            begin
                wr_en           = 1'b1;
                wr_addr         = ins_reg;
                wr_data.key     = key_reg;
                wr_data.kind    = kind_reg;
                wr_data.attr    = attr_reg;
                count_next      = count_reg + CNT_W'(1);
                done_next       = 1'b1;
                status_next     = ST_INSERTED;
                position_next   = out6({1'b0, ins_reg});
                found_kind_next = kind_reg;
                found_attr_next = attr_reg;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Transaction payload and result fields, no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        ins_reg        <= ins_next;
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        kind_reg       <= kind_next;
        attr_reg       <= attr_next;
        status_reg     <= status_next;
        position_reg   <= position_next;
        found_kind_reg <= found_kind_next;
        found_attr_reg <= found_attr_next;
    end

    // Table memory port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign position        = position_reg;
    assign found_kind      = found_kind_reg;
    assign found_attribute = found_attr_reg;
    assign entry_count     = out6(count_reg);

    // Checks
    `SUKT_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH))
    `SUKT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `SUKT_ASSERT_NOW(a_insert_count, done_reg && status_reg == ST_INSERTED, count_reg == $past(count_reg) + CNT_W'(1))
    `SUKT_ASSERT_NOW(a_miss_position, done_reg && (status_reg == ST_NOT_FOUND || status_reg == ST_FULL), position_reg == out6(count_reg))

endmodule

### tb/tb_sorted_unique_key_table.sv
// Self-checking testbench of the sorted unique-key table: queued commands, own table model.
`timescale 1ns / 1ps

module tb_sorted_unique_key_table;
    import sukt_pkg::*;

    localparam int RANDOM_ITEMS = 690;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 2 * TABLE_DEPTH + 40;
    localparam int REPORT_MAX   = 10;

    // One table command as queued for the driver
    typedef struct {
        command_t          cmd;
        logic [KEY_W-1:0]  key;
        logic              kind;
        logic [ATTR_W-1:0] attr;
        bit                drain_first;
    } table_cmd_t;

    // One reply of the table
    typedef struct {
        status_t           status;
        logic [OUT_W-1:0]  position;
        logic              kind;
        logic [ATTR_W-1:0] attr;
        logic [OUT_W-1:0]  count;
    } table_reply_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              command;
    logic [KEY_W-1:0]  part_key;
    logic              part_kind;
    logic [ATTR_W-1:0] part_attribute;
    logic              done;
    logic [2:0]        status;
    logic [OUT_W-1:0]  position;
    logic              found_kind;
    logic [ATTR_W-1:0] found_attribute;
    logic [OUT_W-1:0]  entry_count;

    table_cmd_t   cmd_queue[$];
    table_reply_t pending_replies[$];
    logic [KEY_W-1:0] key_pool[$];

    // Shadow copy of the table
    logic [KEY_W-1:0]  shadow_keys[TABLE_DEPTH];
    logic              shadow_kinds[TABLE_DEPTH];
    logic [ATTR_W-1:0] shadow_attrs[TABLE_DEPTH];
    int                shadow_count;

    int  mismatch_count;
    int  idle_cycles;
    bit  xact_taken;
    int  gap_left;
    int  burst_left;

    sorted_unique_key_table u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .part_key        (part_key),
        .part_kind       (part_kind),
        .part_attribute  (part_attribute),
        .done            (done),
        .status          (status),
        .position        (position),
        .found_kind      (found_kind),
        .found_attribute (found_attribute),
        .entry_count     (entry_count)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one command to the shadow table and returns the reply it gives
    function automatic table_reply_t sorted_table_apply(table_cmd_t c);
        table_reply_t r;
        int           hit;
        int           ins;
        hit = shadow_count;
        for (int i = 0; i < shadow_count; i++)
        begin
            if (hit == shadow_count && shadow_keys[i] == c.key)
                hit = i;
        end
        r.position = hit[OUT_W-1:0];
        r.kind     = 1'b0;
        r.attr     = '0;
        if (hit < shadow_count)
        begin
            r.status = (c.cmd == CMD_LOOKUP) ? ST_FOUND : ST_DUPLICATE;
            r.kind   = shadow_kinds[hit];
            r.attr   = shadow_attrs[hit];
        end
        else if (c.cmd == CMD_LOOKUP)
            r.status = ST_NOT_FOUND;
        else if (shadow_count >= TABLE_DEPTH)
            r.status = ST_FULL;
        else
        begin
            ins = 0;
            while (ins < shadow_count && shadow_keys[ins] < c.key)
                ins++;
            for (int j = shadow_count; j > ins; j--)
            begin
                shadow_keys[j]  = shadow_keys[j-1];
                shadow_kinds[j] = shadow_kinds[j-1];
                shadow_attrs[j] = shadow_attrs[j-1];
            end
            shadow_keys[ins]  = c.key;
            shadow_kinds[ins] = c.kind;
            shadow_attrs[ins] = c.attr;
            shadow_count++;
            r.status   = ST_INSERTED;
            r.position = ins[OUT_W-1:0];
            r.kind     = c.kind;
            r.attr     = c.attr;
        end
        r.count = shadow_count[OUT_W-1:0];
        return r;
    endfunction

    task automatic queue_cmd(command_t cmd, logic [KEY_W-1:0] key, logic kind,
                             logic [ATTR_W-1:0] attr, bit drain_first);
        table_cmd_t c;
        c.cmd         = cmd;
        c.key         = key;
        c.kind        = kind;
        c.attr        = attr;
        c.drain_first = drain_first;
        cmd_queue.push_back(c);
        key_pool.push_back(key);
    endtask

    // Monitor: record accepted transactions, check replies, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles = idle_cycles + 1;
            if (start && !busy)
            begin
                table_cmd_t c;
                c.cmd         = command_t'(command);
                c.key         = part_key;
                c.kind        = part_kind;
                c.attr        = part_attribute;
                c.drain_first = 1'b0;
                pending_replies.push_back(sorted_table_apply(c));
                xact_taken  = 1'b1;
                idle_cycles = 0;
            end
            if (done)
            begin
                idle_cycles = 0;
                if (pending_replies.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("ERROR: reply with nothing pending, status %0d pos %0d",
                                 status, position);
                end
                else
                begin
                    table_reply_t e;
                    e = pending_replies.pop_front();
                    if (status !== e.status || position !== e.position
                        || found_kind !== e.kind || found_attribute !== e.attr
                        || entry_count !== e.count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                        begin
                            $display("ERROR: expected status %0d pos %0d kind %0d attr %h cnt %0d",
                                     e.status, e.position, e.kind, e.attr, e.count);
                            $display("       actual   status %0d pos %0d kind %0d attr %h cnt %0d",
                                     status, position, found_kind, found_attribute,
                                     entry_count);
                        end
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Driver: bursts of commands with random gaps, held until accepted
    always @(negedge clk)
    begin
        if (rst_n && !(start && !xact_taken))
        begin
            xact_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end
            else if (cmd_queue.size() == 0)
                start <= 1'b0;
            else if (cmd_queue[0].drain_first && (pending_replies.size() != 0 || busy))
                start <= 1'b0;
            else
            begin
                table_cmd_t c;
                c = cmd_queue.pop_front();
                command        <= c.cmd;
                part_key       <= c.key;
                part_kind      <= c.kind;
                part_attribute <= c.attr;
                start          <= 1'b1;
                burst_left = burst_left - 1;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 8);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        logic [KEY_W-1:0] k;
        int               sel;
        rst_n          = 1'b0;
        start          = 1'b0;
        command        = CMD_INSERT;
        part_key       = '0;
        part_kind      = 1'b0;
        part_attribute = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        xact_taken     = 1'b0;
        gap_left       = 0;
        burst_left     = 4;
        shadow_count   = 0;

        // Directed: empty miss, head/tail/middle inserts, duplicate, hits, misses
        queue_cmd(CMD_LOOKUP, 32'h0000_0000, 1'b1, 16'hFFFF, 1'b0);
        queue_cmd(CMD_INSERT, 32'h8000_0000, 1'b1, 16'hFFFF, 1'b0);
        queue_cmd(CMD_INSERT, 32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0);
        queue_cmd(CMD_INSERT, 32'h0000_0000, 1'b1, 16'h5A5A, 1'b0);
        queue_cmd(CMD_INSERT, 32'h8000_0000, 1'b0, 16'h1234, 1'b0);
        queue_cmd(CMD_LOOKUP, 32'h0000_0000, 1'b0, 16'h0000, 1'b0);
        queue_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b0);
        queue_cmd(CMD_LOOKUP, 32'h1234_5678, 1'b1, 16'hA5A5, 1'b0);
        queue_cmd(CMD_INSERT, 32'h0000_0001, 1'b0, 16'hAAAA, 1'b1);
        queue_cmd(CMD_LOOKUP, 32'h0000_0001, 1'b0, 16'h0000, 1'b0);
        queue_cmd(CMD_INSERT, 32'h7FFF_FFFF, 1'b1, 16'h5555, 1'b0);
        queue_cmd(CMD_INSERT, 32'hFFFF_FFFE, 1'b0, 16'h8001, 1'b0);
        queue_cmd(CMD_LOOKUP, 32'h8000_0000, 1'b0, 16'h0000, 1'b0);
        queue_cmd(CMD_LOOKUP, 32'h7FFF_FFFF, 1'b0, 16'h0000, 1'b0);
        queue_cmd(CMD_INSERT, 32'h0000_0001, 1'b1, 16'hFFFF, 1'b0);
        queue_cmd(CMD_LOOKUP, 32'hFFFF_FFFE, 1'b1, 16'h0001, 1'b0);

        // Random: mostly keys seen before, some near the extremes, rest fresh;
        // the table fills early, so later inserts exercise the full case
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 5)
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else if (sel < 7)
            begin
                case ($urandom_range(0, 3))
                    0: k = $urandom_range(0, 15);
                    1: k = 32'hFFFF_FFFF - $urandom_range(0, 15);
                    2: k = 32'h8000_0000 + $urandom_range(0, 7) - 4;
                    default: k = $urandom;
                endcase
            end
            else
                k = $urandom;
            queue_cmd(($urandom_range(0, 99) < 55) ? CMD_INSERT : CMD_LOOKUP, k,
                      1'($urandom_range(0, 1)), ATTR_W'($urandom_range(0, 65535)),
                      (n % 97) == 50);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for the last command to go in and every reply to come back
        while (cmd_queue.size() != 0 || start)
            @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
